[src/rdpt_pkg.sv]
// Shared types, constants and helper functions of the retriggerable delayed pulse timer.
// No dependencies; used by rdpt_csr, rdpt_core and the top level.
`default_nettype none

package rdpt_pkg;

   localparam int unsigned TICKS_PER_SECOND  = 100;
   localparam int unsigned INITIAL_DELAY_SEC = 5;
   localparam int unsigned PULSE_SECONDS     = 3;
   localparam int unsigned RETRIGGER_SECONDS = 10;
   localparam int unsigned DEBOUNCE_DEFAULT  = 2;

   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned RUN_W      = 4;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

   localparam logic [COUNT_W-1:0] DELAY_RESET     =
      COUNT_W'(INITIAL_DELAY_SEC * TICKS_PER_SECOND);
   localparam logic [COUNT_W-1:0] PULSE_RESET     = COUNT_W'(PULSE_SECONDS * TICKS_PER_SECOND);
   localparam logic [COUNT_W-1:0] RETRIGGER_RESET =
      COUNT_W'(RETRIGGER_SECONDS * TICKS_PER_SECOND);
   localparam logic [RUN_W-1:0]   DEBOUNCE_RESET  = RUN_W'(DEBOUNCE_DEFAULT);

   // Reported phase codes.
   localparam logic [PHASE_W-1:0] CODE_AWAIT_LOW  = 3'd0;
   localparam logic [PHASE_W-1:0] CODE_AWAIT_HIGH = 3'd1;
   localparam logic [PHASE_W-1:0] CODE_DELAY      = 3'd2;
   localparam logic [PHASE_W-1:0] CODE_PULSE      = 3'd3;
   localparam logic [PHASE_W-1:0] CODE_MONITOR    = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_DELAY = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE         = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RETRIGGER     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE      = 8'd3;

   typedef enum logic [4:0] {
      PH_AWAIT_LOW  = 5'b00001,
      PH_AWAIT_HIGH = 5'b00010,
      PH_DELAY      = 5'b00100,
      PH_PULSE      = 5'b01000,
      PH_MONITOR    = 5'b10000
   } phase_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] initial_delay_ticks;
      logic [COUNT_W-1:0] pulse_ticks;
      logic [COUNT_W-1:0] retrigger_ticks;
      logic [RUN_W-1:0]   debounce_ticks;
   } cfg_type;

   function automatic logic [PHASE_W-1:0] phase_code(input phase_state_type ph);
      logic [PHASE_W-1:0] code;
      case (ph)
         PH_AWAIT_LOW:  code = CODE_AWAIT_LOW;
         PH_AWAIT_HIGH: code = CODE_AWAIT_HIGH;
         PH_DELAY:      code = CODE_DELAY;
         PH_PULSE:      code = CODE_PULSE;
         PH_MONITOR:    code = CODE_MONITOR;
         default:       code = CODE_AWAIT_LOW;
      endcase
      return code;
   endfunction

   // Saturating increment of the interval counter.
   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
      return (v != COUNT_MAX) ? v + COUNT_W'(1) : v;
   endfunction

endpackage

`default_nettype wire

[src/rdpt_csr.sv]
// Configuration register file of the retriggerable delayed pulse timer.
// Depends on rdpt_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module rdpt_csr (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [rdpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [rdpt_pkg::CSR_DATA_W-1:0] csr_data,
   output rdpt_pkg::cfg_type               cfg
);
   import rdpt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always accepted: csr_ready is held high.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_INITIAL_DELAY: cfg_in.initial_delay_ticks = csr_data[COUNT_W-1:0];
            REG_PULSE:         cfg_in.pulse_ticks         = csr_data[COUNT_W-1:0];
            REG_RETRIGGER:     cfg_in.retrigger_ticks     = csr_data[COUNT_W-1:0];
            REG_DEBOUNCE:      cfg_in.debounce_ticks      = csr_data[RUN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_delay_ticks <= DELAY_RESET;
         cfg_ff.pulse_ticks         <= PULSE_RESET;
         cfg_ff.retrigger_ticks     <= RETRIGGER_RESET;
         cfg_ff.debounce_ticks      <= DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[src/rdpt_core.sv]
// Tick engine: phase state, interval counter, level run tracker and the result register.
// Depends on rdpt_pkg for the phase enum, cfg_type and helper functions.
`default_nettype none

module rdpt_core (
   input  wire                           clock,
   input  wire                           reset,
   input  rdpt_pkg::cfg_type             cfg,
   input  wire                           tick_valid,
   output logic                          tick_ready,
   input  wire                           trigger_level,
   output logic                          out_valid,
   input  wire                           out_ready,
   output logic                          drive_level,
   output logic [rdpt_pkg::PHASE_W-1:0]  phase
);
   import rdpt_pkg::*;

   phase_state_type     phase_ff, phase_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [RUN_W-1:0]    run_len_ff, run_len_in;
   logic                run_level_ff, run_level_in;
   logic                valid_ff, valid_in;
   logic                drive_ff, drive_in;
   logic [PHASE_W-1:0]  phase_code_ff, phase_code_in;

   logic                trk_level;
   logic [RUN_W-1:0]    trk_len;
   logic                stable_low, stable_high;
   logic [COUNT_W-1:0]  count_bumped;
   logic                accept;

   // A new tick is taken whenever the result register is empty or drains this cycle.
   assign tick_ready = !valid_ff || out_ready;
   assign accept     = tick_valid && tick_ready;

   // Run tracker update for this tick's sample.
   always_comb begin
      if (trigger_level == run_level_ff) begin
         trk_level = run_level_ff;
         trk_len   = (run_len_ff != RUN_MAX) ? run_len_ff + RUN_W'(1) : run_len_ff;
      end else begin
         trk_level = trigger_level;
         trk_len   = '0;
      end
      stable_low   = !trk_level && (trk_len >= cfg.debounce_ticks);
      stable_high  = trk_level && (trk_len >= cfg.debounce_ticks);
   end

   assign count_bumped = bump(count_ff);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      run_len_in   = run_len_ff;
      run_level_in = run_level_ff;
      if (accept) begin
         case (phase_ff)
            PH_AWAIT_LOW: begin
               run_level_in = trk_level;
               run_len_in   = trk_len;
               if (stable_low) begin
                  phase_in = PH_AWAIT_HIGH;
               end
            end
            PH_AWAIT_HIGH: begin
               run_level_in = trk_level;
               run_len_in   = trk_len;
               if (stable_high) begin
                  run_level_in = 1'b1;
                  run_len_in   = '0;
                  count_in     = '0;
                  phase_in     = (cfg.initial_delay_ticks == '0) ? PH_PULSE : PH_DELAY;
               end
            end
            PH_DELAY: begin
               count_in = count_bumped;
               if (count_bumped >= cfg.initial_delay_ticks) begin
                  phase_in = PH_PULSE;
                  count_in = '0;
               end
            end
            PH_PULSE: begin
               count_in = count_bumped;
               if (count_bumped >= cfg.pulse_ticks) begin
                  phase_in     = PH_MONITOR;
                  count_in     = '0;
                  run_level_in = 1'b1;
                  run_len_in   = '0;
               end
            end
            PH_MONITOR: begin
               run_level_in = trk_level;
               run_len_in   = trk_len;
               if (trigger_level) begin
                  count_in = count_bumped;
                  if (count_bumped >= cfg.retrigger_ticks) begin
                     phase_in = PH_PULSE;
                     count_in = '0;
                  end
               end else begin
                  count_in = '0;
                  if (stable_low) begin
                     phase_in = PH_AWAIT_HIGH;
                  end
               end
            end
            default: begin
               phase_in     = PH_AWAIT_LOW;
               count_in     = '0;
               run_len_in   = '0;
               run_level_in = 1'b0;
            end
         endcase
      end
   end

   // Result register: loaded on every accepted tick, emptied when taken.
   always_comb begin
      valid_in      = valid_ff;
      drive_in      = drive_ff;
      phase_code_in = phase_code_ff;
      if (accept) begin
         valid_in      = 1'b1;
         drive_in      = (phase_in == PH_PULSE);
         phase_code_in = phase_code(phase_in);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_AWAIT_LOW;
         count_ff     <= '0;
         run_len_ff   <= '0;
         run_level_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         run_len_ff   <= run_len_in;
         run_level_ff <= run_level_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drive_ff      <= drive_in;
      phase_code_ff <= phase_code_in;
   end

   assign out_valid   = valid_ff;
   assign drive_level = drive_ff;
   assign phase       = phase_code_ff;

endmodule

`default_nettype wire

[src/retriggerable_delayed_pulse_timer.sv]
// Top level of the retriggerable delayed pulse timer.
// Depends on rdpt_pkg, rdpt_csr and rdpt_core.
`default_nettype none

// Channel  | Ports                        | Contents
// ---------+------------------------------+--------------------------------------
// req      | req_tvalid/tready/tdata[7:0] | one tick: [0] trigger_level
// rsp      | rsp_tvalid/tready/tdata[7:0] | one result: [0] drive_level, [3:1] phase
// csr      | csr_valid/ready/index/data   | register write, index 0..3
//
// For every tick the phase, interval counter and run tracker update in the cycle of
// the req transfer and the result sits in the rsp register on the next cycle.
// A tick is taken in every cycle while the result register is empty or being drained,
// so a stall on rsp holds req_tready low only while the previous result is waiting.
// Synchronous active-high reset returns the timer to await-low with empty result
// register and loads the default delay, pulse, retrigger and debounce values.
// Configuration writes are always accepted and take effect on the next tick.

module retriggerable_delayed_pulse_timer (
   input  wire                             clock,
   input  wire                             reset,
   // Input ticks.
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [7:0]                      req_tdata,   // [0] trigger_level, [7:1] zero
   // Results.
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [0] drive_level, [3:1] phase
   // Configuration writes.
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [rdpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [rdpt_pkg::CSR_DATA_W-1:0] csr_data
);
   import rdpt_pkg::*;

   cfg_type            cfg;
   logic               drive_level;
   logic [PHASE_W-1:0] phase;

   rdpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rdpt_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .tick_valid    (req_tvalid),
      .tick_ready    (req_tready),
      .trigger_level (req_tdata[0]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .drive_level   (drive_level),
      .phase         (phase)
   );

   // The upper bits carry nothing and are held at zero.
   assign rsp_tdata = {4'b0000, phase, drive_level};

   // The pin is high exactly while the reported phase is the pulse phase.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] == CODE_PULSE)))
      else $error("drive_level disagrees with reported phase");

   // Every accepted tick leaves a result waiting on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted tick produced no result");

   // A waiting result that is not taken blocks the next tick.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("tick accepted while result stalled");

   // Reported phase codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:1] <= CODE_MONITOR))
      else $error("phase code out of range");

endmodule

`default_nettype wire

[dv/retriggerable_delayed_pulse_timer_test.sv]
// Self-checking testbench for the retriggerable delayed pulse timer.
// Depends on rdpt_pkg and on the retriggerable_delayed_pulse_timer top level.
`default_nettype none

module retriggerable_delayed_pulse_timer_test;

   import rdpt_pkg::*;

   // A watchdog ends the run after this many cycles without any transfer on any channel.
   localparam int unsigned QUIET_LIMIT      = 2000;
   // Length of the long receiver hold-off that backs the block up into its input.
   localparam int unsigned HOLD_OFF_CYCLES  = 40;
   // Cycles allowed after the last result before the block counts as idle.
   localparam int unsigned SETTLE_CYCLES    = 5;
   localparam int unsigned MAX_REPORTS      = 10;
   localparam int unsigned RANDOM_PHASES    = 14;
   localparam int unsigned TICKS_PER_PHASE  = 76;

   // One expected result: the output pin level and the reported phase code.
   typedef struct packed {
      logic               drive_level;
      logic [PHASE_W-1:0] phase;
   } timer_result_type;

   // The scoreboard carries its own copy of the timer state and configuration. Every
   // accepted tick advances that copy and queues the result it produces; every result
   // transfer is compared with the oldest queued entry.
   class pulse_timer_scoreboard;
      logic [COUNT_W-1:0] delay_len;
      logic [COUNT_W-1:0] pulse_len;
      logic [COUNT_W-1:0] retrigger_len;
      logic [RUN_W-1:0]   debounce_len;
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] interval;
      logic [RUN_W-1:0]   run_len;
      logic               run_level;
      timer_result_type   expected_results[$];
      int unsigned        mismatches;

      function new();
         delay_len     = DELAY_RESET;
         pulse_len     = PULSE_RESET;
         retrigger_len = RETRIGGER_RESET;
         debounce_len  = DEBOUNCE_RESET;
         phase         = CODE_AWAIT_LOW;
         interval      = '0;
         run_len       = '0;
         run_level     = 1'b0;
         mismatches    = 0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_INITIAL_DELAY: delay_len     = value;
            REG_PULSE:         pulse_len     = value;
            REG_RETRIGGER:     retrigger_len = value;
            REG_DEBOUNCE:      debounce_len  = value[RUN_W-1:0];
            default: ;
         endcase
      endfunction

      // The run tracker counts extra equal samples and saturates at its maximum.
      function void follow_level(input logic level);
         if (level == run_level) begin
            if (run_len != RUN_MAX) run_len++;
         end else begin
            run_level = level;
            run_len   = '0;
         end
      endfunction

      function bit level_settled(input logic level);
         return (run_level == level) && (run_len >= debounce_len);
      endfunction

      function void restart_run();
         run_level = 1'b1;
         run_len   = '0;
      endfunction

      function void begin_pulse();
         phase    = CODE_PULSE;
         interval = '0;
      endfunction

      function void count_up();
         if (interval != COUNT_MAX) interval++;
      endfunction

      function void note_tick(input logic level);
         timer_result_type result;
         case (phase)
            CODE_AWAIT_LOW: begin
               follow_level(level);
               if (level_settled(1'b0)) phase = CODE_AWAIT_HIGH;
            end
            CODE_AWAIT_HIGH: begin
               follow_level(level);
               if (level_settled(1'b1)) begin
                  restart_run();
                  interval = '0;
                  if (delay_len == '0) begin_pulse();
                  else phase = CODE_DELAY;
               end
            end
            CODE_DELAY: begin
               // The trigger is ignored while the delay runs.
               count_up();
               if (interval >= delay_len) begin_pulse();
            end
            CODE_PULSE: begin
               count_up();
               if (interval >= pulse_len) begin
                  phase    = CODE_MONITOR;
                  interval = '0;
                  restart_run();
               end
            end
            CODE_MONITOR: begin
               follow_level(level);
               if (level) begin
                  count_up();
                  if (interval >= retrigger_len) begin_pulse();
               end else begin
                  interval = '0;
                  if (level_settled(1'b0)) phase = CODE_AWAIT_HIGH;
               end
            end
            default: begin
               phase     = CODE_AWAIT_LOW;
               interval  = '0;
               run_len   = '0;
               run_level = 1'b0;
            end
         endcase
         result.drive_level = (phase == CODE_PULSE);
         result.phase       = phase;
         expected_results.push_back(result);
      endfunction

      function void check_result(input logic drive_level, input logic [PHASE_W-1:0] phase_seen);
         timer_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Unexpected result: drive_level %0d phase %0d", drive_level, phase_seen);
            return;
         end
         want = expected_results.pop_front();
         if (want.drive_level !== drive_level || want.phase !== phase_seen) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Result mismatch: drive_level expected %0d got %0d, %s %0d got %0d",
                        want.drive_level, drive_level, "phase expected", want.phase,
                        phase_seen);
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // [0] trigger_level, [7:1] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // [0] drive_level, [3:1] phase, [7:4] zero
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Shared between the stimulus and the result sink. In a steady phase neither side
   // idles; a stall request makes the sink hold off for a long stretch once.
   bit                    steady        = 1'b0;
   bit                    stall_request = 1'b0;
   int unsigned           quiet_cycles  = 0;

   pulse_timer_scoreboard sb = new();

   retriggerable_delayed_pulse_timer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Any transfer on any channel counts as progress. All signals are sampled at the
   // rising edge, before the nonblocking updates of that edge take effect.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // Result sink: draws a random wait before each transfer, or the long hold-off when
   // one is requested. The ready line is changed at most once per edge: it is only
   // lowered at the edge of a transfer when a wait follows.
   initial begin : result_sink
      int unsigned wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = steady ? 0 : $urandom_range(0, 3);
         if (stall_request) begin
            wait_cycles   = HOLD_OFF_CYCLES;
            stall_request = 1'b0;
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata[0], rsp_tdata[3:1]);
      end
   end

   // Offers one tick and returns at the edge of its transfer. The valid line stays high
   // into the next tick when no gap is drawn, so it is never lowered and raised at once.
   task automatic send_tick(input logic level);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(level);
   endtask

   // Drops the valid line at the edge of the last transfer and waits for every result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic program_register(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(index, value);
   endtask

   // Registers change only while the timer is idle: all results are in and the last
   // tick has had time to leave the pipeline.
   task automatic reconfigure(input logic [CSR_DATA_W-1:0] delay_len,
                              input logic [CSR_DATA_W-1:0] pulse_len,
                              input logic [CSR_DATA_W-1:0] retrigger_len,
                              input logic [RUN_W-1:0]      debounce_len);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      program_register(REG_INITIAL_DELAY, delay_len);
      program_register(REG_PULSE, pulse_len);
      program_register(REG_RETRIGGER, retrigger_len);
      program_register(REG_DEBOUNCE, {{(CSR_DATA_W-RUN_W){1'b0}}, debounce_len});
      csr_valid <= 1'b0;
   endtask

   // Sends a fixed pattern of trigger levels, bit 0 first.
   task automatic send_pattern(input logic [15:0] levels, input int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_tick(levels[i]);
   endtask

   // Random ticks shaped as runs of equal levels. Most runs are long enough to pass
   // the debounce so that the timer walks through all of its phases; some high runs
   // are as long as the retrigger count capped at 60; short glitches break up the rest.
   // The valid line is left high; the following drain lowers it.
   task automatic send_random_ticks(input int unsigned count, input int unsigned pause_at);
      int unsigned sent;
      int unsigned run;
      int unsigned long_run;
      logic        level;
      sent  = 0;
      level = $urandom_range(0, 1);
      while (sent < count) begin
         long_run = (sb.retrigger_len > 60) ? 60 : sb.retrigger_len;
         if ($urandom_range(0, 4) == 0)
            run = $urandom_range(1, 2);
         else if (level && $urandom_range(0, 2) == 0)
            run = long_run + $urandom_range(0, 3);
         else
            run = sb.debounce_len + 1 + $urandom_range(0, 3);
         for (int unsigned i = 0; i < run && sent < count; i++) begin
            send_tick(level);
            sent++;
            if (sent == pause_at) drain_results();
         end
         level = !level;
      end
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] delay_len;
      logic [CSR_DATA_W-1:0] pulse_len;
      logic [CSR_DATA_W-1:0] retrigger_len;
      logic [RUN_W-1:0]      debounce_len;
      int unsigned           pause_at;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a glitch, a debounced low that arms the timer, a debounced
      // high that starts the long default delay.
      send_pattern(16'b0000_0000_1111_0001, 8);

      // Zero delay, one-tick pulse and retrigger, no debounce: the timer is left in
      // delay and must leave it on the next tick; in monitor every high tick pulses,
      // one low tick disarms, and a confirming high goes straight to pulse.
      reconfigure(16'd0, 16'd1, 16'd1, 4'd0);
      send_pattern(16'b0000_0000_1110_0101, 8);

      // Largest debounce: short runs never settle in monitor.
      reconfigure(16'd3, 16'd2, 16'd4, 4'd15);
      send_pattern(16'b0000_0000_1011_0010, 8);

      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            delay_len = COUNT_MAX; pulse_len = COUNT_MAX; retrigger_len = COUNT_MAX;
            debounce_len = RUN_MAX;
         end else if (p == 1) begin
            delay_len = '0; pulse_len = 16'd1; retrigger_len = 16'd1; debounce_len = '0;
         end else if (p % 5 == 2) begin
            // Full-range values; the timer mostly sits in a long delay or pulse.
            delay_len     = $urandom_range(0, 65535);
            pulse_len     = $urandom_range(1, 65535);
            retrigger_len = $urandom_range(1, 65535);
            debounce_len  = $urandom_range(0, 15);
         end else begin
            delay_len     = $urandom_range(0, 6);
            pulse_len     = $urandom_range(1, 6);
            retrigger_len = $urandom_range(1, 10);
            debounce_len  = ($urandom_range(0, 7) == 0) ? RUN_MAX : $urandom_range(0, 4);
         end
         reconfigure(delay_len, pulse_len, retrigger_len, debounce_len);

         steady = (p % 4 == 3);
         // Once, the sink holds off long enough that the block backs up its input.
         if (p == 5) stall_request = 1'b1;
         // Once, the sender stops mid-phase until every result has come back.
         pause_at = (p == 7) ? TICKS_PER_PHASE / 2 : 0;
         send_random_ticks(TICKS_PER_PHASE, pause_at);
      end

      steady = 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
src/rdpt_pkg.sv
src/rdpt_csr.sv
src/rdpt_core.sv
src/retriggerable_delayed_pulse_timer.sv
dv/retriggerable_delayed_pulse_timer_test.sv
